// ----- hdl/modbus_rtu_request_framer_core_assert.svh -----
// Assertion macros for the Modbus RTU request framer.
// Depends on nothing; included by the top level.
`ifndef MODBUS_RTU_REQUEST_FRAMER_CORE_ASSERT_SVH
`define MODBUS_RTU_REQUEST_FRAMER_CORE_ASSERT_SVH

// same-cycle implication under synchronous reset
`define MBRTU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("framer assertion failed");

// next-cycle implication under synchronous reset
`define MBRTU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("framer assertion failed");

`endif

// ----- hdl/mbrtu_pkg.sv -----
// Shared types, constants and CRC step function for the Modbus RTU request framer.
// Depends on nothing.
package mbrtu_pkg;

    localparam int unsigned FRAME_LEN = 8;
    localparam int unsigned HDR_LEN   = 6;

    localparam logic [1:0] MODE_READ_ONE = 2'd0;
    localparam logic [1:0] MODE_READ_TWO = 2'd1;
    localparam logic [1:0] MODE_WRITE    = 2'd2;
    localparam logic [1:0] MODE_NONE     = 2'd3;

    localparam logic       CFG_READ_FC   = 1'b0;
    localparam logic       CFG_WRITE_FC  = 1'b1;

    localparam logic [7:0] READ_FC_RST   = 8'd3;
    localparam logic [7:0] WRITE_FC_RST  = 8'd6;

    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [15:0] QTY_ONE      = 16'h0001;
    localparam logic [15:0] QTY_TWO      = 16'h0002;

    // header bytes, byte 0 (slave address) in the lowest slot
    typedef logic [HDR_LEN-1:0][7:0] t_frame;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- hdl/mbrtu_front.sv -----
// Front end: holds the function code registers, accepts requests and builds headers.
// Depends on mbrtu_pkg.
module mbrtu_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_mode,
    input  logic [7:0]          i_slave_address,
    input  logic [15:0]         i_register_address,
    input  logic [15:0]         i_write_value,
    input  mbrtu_pkg::t_q_stat  i_q_stat,
    output logic                o_push,
    output mbrtu_pkg::t_frame   o_frame
);

    logic [7:0]  r_read_fc;
    logic [7:0]  r_write_fc;
    logic [15:0] payload;
    logic [7:0]  func;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_fc  <= mbrtu_pkg::READ_FC_RST;
            r_write_fc <= mbrtu_pkg::WRITE_FC_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mbrtu_pkg::CFG_READ_FC:  r_read_fc  <= i_cfg_data;
                mbrtu_pkg::CFG_WRITE_FC: r_write_fc <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_mode)
            mbrtu_pkg::MODE_WRITE: begin
                payload = i_write_value;
                func    = r_write_fc;
            end
            mbrtu_pkg::MODE_READ_TWO: begin
                payload = mbrtu_pkg::QTY_TWO;
                func    = r_read_fc;
            end
            default: begin
                payload = mbrtu_pkg::QTY_ONE;
                func    = r_read_fc;
            end
        endcase
    end

    assign o_ready = !i_q_stat.full;
    // drop requests with the unused mode
    assign o_push  = i_valid && o_ready && (i_mode != mbrtu_pkg::MODE_NONE);
    assign o_frame = {payload[7:0], payload[15:8],
                      i_register_address[7:0], i_register_address[15:8],
                      func, i_slave_address};

endmodule

// ----- hdl/mbrtu_queue.sv -----
// Two-entry header queue between the front end and the byte sender.
// Depends on mbrtu_pkg.
module mbrtu_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mbrtu_pkg::t_frame   i_frame,
    input  logic                i_pop,
    output mbrtu_pkg::t_frame   o_frame,
    output mbrtu_pkg::t_q_stat  o_stat
);

    mbrtu_pkg::t_frame r_mem [2];
    logic              r_wr;
    logic              r_rd;
    logic [1:0]        r_cnt;
    logic              do_pop;

    assign do_pop = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (do_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, do_pop};
        end
    end

    assign o_frame      = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

endmodule

// ----- hdl/mbrtu_back.sv -----
// Byte sender: walks the queue head byte by byte and appends the running CRC.
// Depends on mbrtu_pkg.
module mbrtu_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mbrtu_pkg::t_frame   i_frame,
    input  mbrtu_pkg::t_q_stat  i_q_stat,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_byte,
    output logic                o_last
);

    logic [2:0]  r_idx;
    logic [15:0] r_crc;
    logic [2:0]  n_idx;
    logic [15:0] n_crc;
    logic        xfer;

    assign o_valid = !i_q_stat.empty;
    assign o_last  = (r_idx == 3'd7);
    assign xfer    = o_valid && i_ready;
    assign o_pop   = xfer && o_last;

    always_comb begin
        unique case (r_idx)
            3'd0:    o_byte = i_frame[0];
            3'd1:    o_byte = i_frame[1];
            3'd2:    o_byte = i_frame[2];
            3'd3:    o_byte = i_frame[3];
            3'd4:    o_byte = i_frame[4];
            3'd5:    o_byte = i_frame[5];
            3'd6:    o_byte = r_crc[7:0];
            default: o_byte = r_crc[15:8];
        endcase
    end

    always_comb begin
        n_idx = r_idx;
        n_crc = r_crc;
        if (xfer) begin
            if (o_last) begin
                n_idx = 3'd0;
                n_crc = mbrtu_pkg::CRC_INIT;
            end else begin
                n_idx = r_idx + 3'd1;
                if (r_idx < 3'(mbrtu_pkg::HDR_LEN)) begin
                    n_crc = mbrtu_pkg::crc16_byte(r_crc, o_byte);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
            r_crc <= mbrtu_pkg::CRC_INIT;
        end else begin
            r_idx <= n_idx;
            r_crc <= n_crc;
        end
    end

endmodule

// ----- hdl/modbus_rtu_request_framer_core.sv -----
// Top level of the Modbus RTU request framer: front end, header queue, byte sender.
// Depends on mbrtu_pkg, mbrtu_front, mbrtu_queue, mbrtu_back and the assertion header.
//
// Usage:
//   Requests enter on the s_axis channel: tdata carries slave address, register
//   address and write value, tuser carries the mode. A request with mode 3 is
//   accepted and dropped without output.
//   Each request produces eight frame bytes on m_axis, one per transfer, with
//   tlast on the CRC high byte. The CRC is built one byte per cycle as the
//   header bytes leave, and it holds while the receiver stalls.
//   m_axis_tvalid is high in the cycle after a request transfer into an empty queue.
//   The byte-wide output, eight bytes per frame, sets the request rate.
//   A two-entry header queue lets requests be taken while a frame is sent.
//   When the receiver stalls, the current byte holds and the queue fills;
//   s_axis_tready drops once both entries are occupied.
//   Reset (synchronous, active low) empties the queue, restarts the byte
//   counter and restores function codes 3 (read) and 6 (write).
//   The user must write function codes on the cfg port only while the block is idle; the block does not enforce this.
`include "modbus_rtu_request_framer_core_assert.svh"

module modbus_rtu_request_framer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] slave_address, [23:8] register_address, [39:24] write_value
    input  logic [39:0] s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] frame_byte
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast
);

    logic                q_push;
    logic                q_pop;
    mbrtu_pkg::t_frame   q_in;
    mbrtu_pkg::t_frame   q_head;
    mbrtu_pkg::t_q_stat  q_stat;
    logic                unused_xfer;

    mbrtu_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (s_axis_tvalid),
        .o_ready            (s_axis_tready),
        .i_mode             (s_axis_tuser),
        .i_slave_address    (s_axis_tdata[7:0]),
        .i_register_address (s_axis_tdata[23:8]),
        .i_write_value      (s_axis_tdata[39:24]),
        .i_q_stat           (q_stat),
        .o_push             (q_push),
        .o_frame            (q_in)
    );

    mbrtu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_frame (q_in),
        .i_pop   (q_pop),
        .o_frame (q_head),
        .o_stat  (q_stat)
    );

    mbrtu_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (q_head),
        .i_q_stat (q_stat),
        .o_pop    (q_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_byte   (m_axis_tdata),
        .o_last   (m_axis_tlast)
    );

    assign unused_xfer = s_axis_tvalid && s_axis_tready
                         && (s_axis_tuser == mbrtu_pkg::MODE_NONE);

    `MBRTU_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, q_push, !q_stat.full)
    `MBRTU_ASSERT_NOW(a_drop_unused, i_clk, i_rst_n, unused_xfer, !q_push)
    `MBRTU_ASSERT_NEXT(a_fill_shows, i_clk, i_rst_n, q_push, m_axis_tvalid)

endmodule

// ----- sim/tb_modbus_rtu_request_framer_core.sv -----
// Testbench for modbus_rtu_request_framer_core: drives requests and function-code writes,
// predicts every frame byte with its own CRC-16/MODBUS and checks the output stream.
// Depends on mbrtu_pkg and the framer RTL.
module tb_modbus_rtu_request_framer_core;

    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct {
        logic [7:0]  slave;
        logic [1:0]  mode;
        logic [15:0] reg_addr;
        logic [15:0] wr_value;
    } t_request;

    typedef struct {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_frame_byte;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_idx     = mbrtu_pkg::CFG_READ_FC;
    logic [7:0]  i_cfg_data    = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [7:0] slave_address, [23:8] register_address, [39:24] write_value
    logic [39:0] s_axis_tdata  = 40'd0;
    // [1:0] mode
    logic [1:0]  s_axis_tuser  = mbrtu_pkg::MODE_READ_ONE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] frame_byte
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    t_frame_byte frame_bytes_due[$];
    t_frame_byte expected_byte;
    logic [7:0]  read_fc_model   = mbrtu_pkg::READ_FC_RST;
    logic [7:0]  write_fc_model  = mbrtu_pkg::WRITE_FC_RST;
    int          send_idle_pct   = 0;
    int          recv_idle_pct   = 0;
    int          requests_sent   = 0;
    int          requests_dropped = 0;
    int          bytes_checked   = 0;
    int          cfg_writes      = 0;
    int          mismatch_count  = 0;
    int          cycle_count     = 0;

    modbus_rtu_request_framer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes outstanding",
                     cycle_count, frame_bytes_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (frame_bytes_due.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected byte, expected none, actual %02h last %0b",
                         $time, m_axis_tdata, m_axis_tlast);
            end else begin
                expected_byte = frame_bytes_due.pop_front();
                bytes_checked++;
                if (m_axis_tdata !== expected_byte.frame_byte
                        || m_axis_tlast !== expected_byte.last_byte) begin
                    mismatch_count++;
                    $display("%0t: byte mismatch, expected %02h last %0b, actual %02h last %0b",
                             $time, expected_byte.frame_byte, expected_byte.last_byte,
                             m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    function automatic logic [15:0] crc16_of_header(input mbrtu_pkg::t_frame hdr);
        logic [15:0] acc;
        logic        fb;
        acc = mbrtu_pkg::CRC_INIT;
        for (int i = 0; i < mbrtu_pkg::HDR_LEN; i++) begin
            for (int b = 0; b < 8; b++) begin
                fb  = acc[0] ^ hdr[i][b];
                acc = acc >> 1;
                if (fb) begin
                    acc = acc ^ mbrtu_pkg::CRC_POLY;
                end
            end
        end
        return acc;
    endfunction

    function automatic void predict_frame(input t_request r);
        mbrtu_pkg::t_frame hdr;
        logic [15:0]       payload;
        logic [15:0]       crc;
        t_frame_byte       fb;
        if (r.mode == mbrtu_pkg::MODE_NONE) begin
            requests_dropped++;
            return;
        end
        case (r.mode)
            mbrtu_pkg::MODE_WRITE:    payload = r.wr_value;
            mbrtu_pkg::MODE_READ_TWO: payload = mbrtu_pkg::QTY_TWO;
            default:                  payload = mbrtu_pkg::QTY_ONE;
        endcase
        hdr[0] = r.slave;
        hdr[1] = (r.mode == mbrtu_pkg::MODE_WRITE) ? write_fc_model : read_fc_model;
        hdr[2] = r.reg_addr[15:8];
        hdr[3] = r.reg_addr[7:0];
        hdr[4] = payload[15:8];
        hdr[5] = payload[7:0];
        crc = crc16_of_header(hdr);
        for (int i = 0; i < mbrtu_pkg::HDR_LEN; i++) begin
            fb.frame_byte = hdr[i];
            fb.last_byte  = 1'b0;
            frame_bytes_due.push_back(fb);
        end
        fb.frame_byte = crc[7:0];
        fb.last_byte  = 1'b0;
        frame_bytes_due.push_back(fb);
        fb.frame_byte = crc[15:8];
        fb.last_byte  = 1'b1;
        frame_bytes_due.push_back(fb);
    endfunction

    // entered at a rising edge; returns at the edge of the transfer with tvalid still high
    task automatic send_request(input t_request r);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.wr_value, r.reg_addr, r.slave};
        s_axis_tuser  <= r.mode;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        requests_sent++;
        predict_frame(r);
    endtask

    task automatic send_fields(input logic [7:0] slave, input logic [1:0] mode,
                               input logic [15:0] reg_addr, input logic [15:0] wr_value);
        t_request r;
        r.slave    = slave;
        r.mode     = mode;
        r.reg_addr = reg_addr;
        r.wr_value = wr_value;
        send_request(r);
    endtask

    // hold off until every frame byte is out and any dropped request has drained
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (frame_bytes_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_function_codes(input logic [7:0] read_fc, input logic [7:0] write_fc);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= mbrtu_pkg::CFG_READ_FC;
        i_cfg_data <= read_fc;
        @(posedge i_clk);
        read_fc_model = read_fc;
        i_cfg_idx  <= mbrtu_pkg::CFG_WRITE_FC;
        i_cfg_data <= write_fc;
        @(posedge i_clk);
        write_fc_model = write_fc;
        i_cfg_we <= 1'b0;
        cfg_writes += 2;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick16();
        if ($urandom_range(7) == 0) begin
            return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        end
        return 16'($urandom);
    endfunction

    function automatic t_request random_request();
        t_request r;
        r.slave    = 8'(pick16() >> 8);
        r.mode     = ($urandom_range(9) == 0) ? mbrtu_pkg::MODE_NONE
                                               : 2'($urandom_range(2));
        r.reg_addr = pick16();
        r.wr_value = pick16();
        return r;
    endfunction

    task automatic test_default_codes();
        send_fields(8'h00, mbrtu_pkg::MODE_READ_ONE, 16'h0000, 16'h0000);
        send_fields(8'hFF, mbrtu_pkg::MODE_READ_TWO, 16'hFFFF, 16'hFFFF);
        wait_idle();
        send_fields(8'hFF, mbrtu_pkg::MODE_WRITE, 16'hFFFF, 16'hFFFF);
        send_fields(8'h00, mbrtu_pkg::MODE_WRITE, 16'h0000, 16'h0000);
        send_fields(8'h01, mbrtu_pkg::MODE_READ_ONE, 16'h1234, 16'hABCD);
        send_fields(8'h11, mbrtu_pkg::MODE_WRITE, 16'h0001, 16'h8000);
        wait_idle();
    endtask

    task automatic test_unused_mode();
        send_fields(8'hFF, mbrtu_pkg::MODE_NONE, 16'hFFFF, 16'hFFFF);
        send_fields(8'h00, mbrtu_pkg::MODE_NONE, 16'h0000, 16'h0000);
        send_fields(8'h5A, mbrtu_pkg::MODE_READ_TWO, 16'hA55A, 16'h0F0F);
        send_fields(8'hA5, mbrtu_pkg::MODE_NONE, 16'h5AA5, 16'hF0F0);
        send_fields(8'h7E, mbrtu_pkg::MODE_WRITE, 16'h7FFF, 16'h0001);
        wait_idle();
    endtask

    task automatic test_function_code_extremes();
        set_function_codes(8'h00, 8'hFF);
        send_fields(8'h01, mbrtu_pkg::MODE_READ_ONE, 16'h0100, 16'h0000);
        send_fields(8'hFE, mbrtu_pkg::MODE_WRITE, 16'h00FF, 16'hFFFE);
        send_fields(8'h80, mbrtu_pkg::MODE_READ_TWO, 16'h8000, 16'h0000);
        set_function_codes(8'hFF, 8'h00);
        send_fields(8'h7F, mbrtu_pkg::MODE_READ_TWO, 16'hFFFE, 16'h1111);
        send_fields(8'h02, mbrtu_pkg::MODE_WRITE, 16'h0002, 16'h00FF);
        send_fields(8'h03, mbrtu_pkg::MODE_READ_ONE, 16'h0003, 16'h0000);
        set_function_codes(mbrtu_pkg::READ_FC_RST, mbrtu_pkg::WRITE_FC_RST);
        send_fields(8'h10, mbrtu_pkg::MODE_WRITE, 16'h0010, 16'hC0DE);
    endtask

    task automatic test_random_traffic(input int count, input int snd_pct, input int rcv_pct);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        for (int i = 0; i < count; i++) begin
            send_request(random_request());
        end
        set_function_codes(8'($urandom), 8'($urandom));
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 27;
        recv_idle_pct = 46;
        test_default_codes();
        test_unused_mode();
        test_function_code_extremes();
        test_random_traffic(130, 27, 46);
        test_random_traffic(130, 46, 27);
        test_random_traffic(130, 0, 0);
        wait_idle();
        $display("Ran %0d requests (%0d with the unused mode) and checked %0d frame bytes,",
                 requests_sent, requests_dropped, bytes_checked);
        $display("with %0d function-code writes under three sender/receiver stall mixes.",
                 cfg_writes);
        if (mismatch_count == 0 && frame_bytes_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/mbrtu_pkg.sv
hdl/mbrtu_front.sv
hdl/mbrtu_queue.sv
hdl/mbrtu_back.sv
hdl/modbus_rtu_request_framer_core.sv
sim/tb_modbus_rtu_request_framer_core.sv
